FILE: rtl/sobel_pkg.sv
// Shared constants and types for the Sobel edge magnitude core.
`default_nettype none
package sobel_pkg;

    localparam int PIX_W          = 8;
    localparam int CENTRE_COL_W   = 11;
    localparam int CENTRE_ROW_W   = 12;
    localparam int LINE_WIDTH_W   = 12;
    localparam int FRAME_HEIGHT_W = 13;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;

    localparam int DEF_MAX_WIDTH    = 2048;
    localparam int DEF_MAX_HEIGHT   = 4096;
    localparam int RST_LINE_WIDTH   = 640;
    localparam int RST_FRAME_HEIGHT = 480;
    localparam int MIN_DIM          = 3;

    localparam int GRAD_W     = 11;
    localparam int ENERGY_W   = 21;
    localparam int ROOT_IN_W  = 2 * PIX_W;
    localparam int SAT_ENERGY = 65025;

    typedef struct packed {
        logic [PIX_W-1:0] older;
        logic [PIX_W-1:0] newer;
    } t_line_pair;

    typedef struct packed {
        logic                 start;
        logic [ROOT_IN_W-1:0] energy;
    } t_root_req;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [PIX_W-1:0] root;
    } t_root_rsp;

endpackage
`default_nettype wire

FILE: rtl/sobel_in_if.sv
// Pixel request channel: red sample with valid and ready.
`default_nettype none
interface sobel_in_if;
    logic                        valid;
    logic                        ready;
    logic [sobel_pkg::PIX_W-1:0] red_sample;

    modport source (output valid, output red_sample, input ready);
    modport sink   (input valid, input red_sample, output ready);
endinterface
`default_nettype wire

FILE: rtl/sobel_out_if.sv
// Result request channel: edge value, border flag and center position.
`default_nettype none
interface sobel_out_if;
    logic                               valid;
    logic                               ready;
    logic [sobel_pkg::PIX_W-1:0]        edge_value;
    logic                               interior;
    logic [sobel_pkg::CENTRE_COL_W-1:0] centre_col;
    logic [sobel_pkg::CENTRE_ROW_W-1:0] centre_row;

    modport source (output valid, output edge_value, output interior,
                    output centre_col, output centre_row, input ready);
    modport sink   (input valid, input edge_value, input interior,
                    input centre_col, input centre_row, output ready);
endinterface
`default_nettype wire

FILE: rtl/sobel_cfg_if.sv
// Configuration write channel: register index and write data.
`default_nettype none
interface sobel_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [sobel_pkg::CFG_IDX_W-1:0]  index;
    logic [sobel_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/sobel_line_store.sv
// Two-row line store: one synchronous memory holding the older and newer row per column.
`default_nettype none
module sobel_line_store #(
    parameter int MAX_WIDTH = sobel_pkg::DEF_MAX_WIDTH
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rd_en,
    input  wire logic [$clog2(MAX_WIDTH)-1:0] i_rd_addr,
    output      sobel_pkg::t_line_pair        o_rd_data,
    input  wire logic                         i_wr_en,
    input  wire logic [$clog2(MAX_WIDTH)-1:0] i_wr_addr,
    input  wire sobel_pkg::t_line_pair        i_wr_data
);

    sobel_pkg::t_line_pair r_mem [MAX_WIDTH];
    sobel_pkg::t_line_pair r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire

FILE: rtl/sobel_grad.sv
// 3x3 window registers, Sobel X/Y kernels and gradient energy.
`default_nettype none
module sobel_grad (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_load,
    input  wire sobel_pkg::t_line_pair                i_lines,
    input  wire logic [sobel_pkg::PIX_W-1:0]          i_sample,
    output      logic [sobel_pkg::ENERGY_W-1:0]       o_energy
);

    localparam int GW = sobel_pkg::GRAD_W;

    logic [sobel_pkg::PIX_W-1:0] r_win [9];
    logic [sobel_pkg::PIX_W-1:0] n_win [9];
    logic signed [GW-1:0]        r_px;
    logic signed [GW-1:0]        r_py;
    logic signed [GW-1:0]        n_px;
    logic signed [GW-1:0]        n_py;
    logic [GW-1:0]               px_pos;
    logic [GW-1:0]               px_neg;
    logic [GW-1:0]               py_pos;
    logic [GW-1:0]               py_neg;
    logic signed [2*GW-1:0]      sq_x;
    logic signed [2*GW-1:0]      sq_y;
    logic [sobel_pkg::ENERGY_W-1:0] r_energy;

    always_comb begin
        n_win[0] = r_win[1];
        n_win[1] = r_win[2];
        n_win[2] = i_lines.older;
        n_win[3] = r_win[4];
        n_win[4] = r_win[5];
        n_win[5] = i_lines.newer;
        n_win[6] = r_win[7];
        n_win[7] = r_win[8];
        n_win[8] = i_sample;

        px_pos = GW'(n_win[2]) + (GW'(n_win[5]) << 1) + GW'(n_win[8]);
        px_neg = GW'(n_win[0]) + (GW'(n_win[3]) << 1) + GW'(n_win[6]);
        py_pos = GW'(n_win[6]) + (GW'(n_win[7]) << 1) + GW'(n_win[8]);
        py_neg = GW'(n_win[0]) + (GW'(n_win[1]) << 1) + GW'(n_win[2]);
        n_px   = $signed(px_pos - px_neg);
        n_py   = $signed(py_pos - py_neg);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 9; i++) begin
                r_win[i] <= '0;
            end
        end else if (i_load) begin
            r_win <= n_win;
        end
    end

    assign sq_x = r_px * r_px;
    assign sq_y = r_py * r_py;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_px <= n_px;
            r_py <= n_py;
        end
        r_energy <= $unsigned(sobel_pkg::ENERGY_W'(sq_x)) + $unsigned(sobel_pkg::ENERGY_W'(sq_y));
    end

    assign o_energy = r_energy;

endmodule
`default_nettype wire

FILE: rtl/sobel_root.sv
// Iterative ceiling square root, one result bit per cycle plus a rounding step.
`default_nettype none
module sobel_root (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire sobel_pkg::t_root_req i_req,
    output      sobel_pkg::t_root_rsp o_rsp
);

    localparam int RW = sobel_pkg::PIX_W;

    logic                              r_busy;
    logic                              r_done;
    logic [RW-1:0]                     r_mask;
    logic [RW-1:0]                     r_root;
    logic [sobel_pkg::ROOT_IN_W-1:0]   r_energy;
    logic [RW-1:0]                     trial;
    logic [RW-1:0]                     operand;
    logic [sobel_pkg::ROOT_IN_W-1:0]   square;

    assign trial   = r_root | r_mask;
    assign operand = (r_mask == '0) ? r_root : trial;
    assign square  = sobel_pkg::ROOT_IN_W'(operand) * sobel_pkg::ROOT_IN_W'(operand);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_mask == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_energy <= i_req.energy;
            r_root   <= '0;
            r_mask   <= {1'b1, {(RW-1){1'b0}}};
        end else if (r_busy) begin
            if (r_mask != '0) begin
                if (square <= r_energy) begin
                    r_root <= trial;
                end
                r_mask <= r_mask >> 1;
            end else if (square < r_energy) begin
                r_root <= r_root + RW'(1);
            end
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.root = r_root;

endmodule
`default_nettype wire

FILE: rtl/sobel_edge_magnitude_core.sv
// Sobel 3x3 edge magnitude core: raster counters, sequencer and result register.
// Sequence: an accepted request passes through the READ, GRAD and SQR states, then to
// DONE for border or saturated pixels, or via ROOT (9-step square-root unit) for interior.
// Flow: a new request is taken only after the result is loaded; input ready only in idle.
// Reset: synchronous active low; geometry returns to 640x480, position to zero,
// window cleared; line store contents are not cleared.
`default_nettype none
module sobel_edge_magnitude_core #(
    parameter int MAX_WIDTH  = sobel_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = sobel_pkg::DEF_MAX_HEIGHT
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    sobel_in_if.sink   i_pix,
    sobel_cfg_if.sink  i_cfg,
    sobel_out_if.source o_edge
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int WID_W = $clog2(MAX_WIDTH + 1);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int HGT_W = $clog2(MAX_HEIGHT + 1);
    localparam int W_RST = (sobel_pkg::RST_LINE_WIDTH > MAX_WIDTH) ?
                           MAX_WIDTH : sobel_pkg::RST_LINE_WIDTH;
    localparam int H_RST = (sobel_pkg::RST_FRAME_HEIGHT > MAX_HEIGHT) ?
                           MAX_HEIGHT : sobel_pkg::RST_FRAME_HEIGHT;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_READ = 6'b000010,
        S_GRAD = 6'b000100,
        S_SQR  = 6'b001000,
        S_ROOT = 6'b010000,
        S_DONE = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    logic [WID_W-1:0] r_width;
    logic [HGT_W-1:0] r_height;
    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;
    logic [COL_W-1:0] r_cur_col;
    logic [COL_W-1:0] r_cc;
    logic [ROW_W-1:0] r_rr;
    logic             r_inner;
    logic [sobel_pkg::PIX_W-1:0] r_sample;
    logic [sobel_pkg::PIX_W-1:0] r_value;
    logic [sobel_pkg::PIX_W-1:0] n_value;

    logic                              r_out_valid;
    logic [sobel_pkg::PIX_W-1:0]       r_out_edge;
    logic                              r_out_interior;
    logic [sobel_pkg::CENTRE_COL_W-1:0] r_out_col;
    logic [sobel_pkg::CENTRE_ROW_W-1:0] r_out_row;

    logic in_acc;
    logic cfg_acc;
    logic out_load;

    logic [sobel_pkg::LINE_WIDTH_W-1:0]   cfg_lw;
    logic [sobel_pkg::FRAME_HEIGHT_W-1:0] cfg_fh;
    logic [WID_W-1:0] cfg_width;
    logic [HGT_W-1:0] cfg_height;

    logic [COL_W-1:0] c_use;
    logic [ROW_W-1:0] row_use;
    logic [WID_W-1:0] c_ext;
    logic [HGT_W-1:0] row_ext;
    logic [WID_W-1:0] cc_ext;
    logic [HGT_W-1:0] rr_ext;
    logic             inner;
    logic [WID_W-1:0] c_nxt;
    logic [HGT_W-1:0] row_nxt;

    sobel_pkg::t_line_pair rd_lines;
    sobel_pkg::t_line_pair wr_lines;
    logic [sobel_pkg::ENERGY_W-1:0] energy;
    logic                           sat;
    sobel_pkg::t_root_req           root_req;
    sobel_pkg::t_root_rsp           root_rsp;

    assign in_acc      = i_pix.valid && i_pix.ready;
    assign i_pix.ready = (r_state == S_IDLE);
    assign cfg_acc     = i_cfg.valid && i_cfg.ready;
    assign i_cfg.ready = 1'b1;

    // clamp geometry on write
    always_comb begin
        cfg_lw = i_cfg.data[sobel_pkg::LINE_WIDTH_W-1:0];
        cfg_fh = i_cfg.data[sobel_pkg::FRAME_HEIGHT_W-1:0];
        if (32'(cfg_lw) > MAX_WIDTH) begin
            cfg_width = WID_W'(MAX_WIDTH);
        end else if (32'(cfg_lw) < sobel_pkg::MIN_DIM) begin
            cfg_width = WID_W'(sobel_pkg::MIN_DIM);
        end else begin
            cfg_width = WID_W'(cfg_lw);
        end
        if (32'(cfg_fh) > MAX_HEIGHT) begin
            cfg_height = HGT_W'(MAX_HEIGHT);
        end else if (32'(cfg_fh) < sobel_pkg::MIN_DIM) begin
            cfg_height = HGT_W'(sobel_pkg::MIN_DIM);
        end else begin
            cfg_height = HGT_W'(cfg_fh);
        end
    end

    // center position and border test
    always_comb begin
        c_use   = (WID_W'(r_col) >= r_width) ? '0 : r_col;
        row_use = (HGT_W'(r_row) >= r_height) ? '0 : r_row;
        c_ext   = WID_W'(c_use);
        row_ext = HGT_W'(row_use);
        if (c_use == '0) begin
            cc_ext = r_width - WID_W'(1);
            rr_ext = (row_ext >= HGT_W'(2)) ? row_ext - HGT_W'(2)
                                            : row_ext + (r_height - HGT_W'(2));
        end else begin
            cc_ext = c_ext - WID_W'(1);
            rr_ext = (row_ext >= HGT_W'(1)) ? row_ext - HGT_W'(1) : r_height - HGT_W'(1);
        end
        inner = (rr_ext != '0) && (rr_ext <= r_height - HGT_W'(2)) &&
                (cc_ext != '0) && (cc_ext <= r_width - WID_W'(2));
        c_nxt   = c_ext + WID_W'(1);
        row_nxt = row_ext + HGT_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WID_W'(W_RST);
            r_height <= HGT_W'(H_RST);
            r_col    <= '0;
            r_row    <= '0;
        end else if (cfg_acc) begin
            unique case (i_cfg.index)
                sobel_pkg::CFG_LINE_WIDTH: begin
                    r_width <= cfg_width;
                    r_col   <= '0;
                    r_row   <= '0;
                end
                sobel_pkg::CFG_FRAME_HEIGHT: begin
                    r_height <= cfg_height;
                    r_col    <= '0;
                    r_row    <= '0;
                end
                default: begin
                end
            endcase
        end else if (in_acc) begin
            if (c_nxt >= r_width) begin
                r_col <= '0;
                r_row <= (row_nxt >= r_height) ? '0 : ROW_W'(row_nxt);
            end else begin
                r_col <= COL_W'(c_nxt);
                r_row <= row_use;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_sample  <= i_pix.red_sample;
            r_cur_col <= c_use;
            r_cc      <= COL_W'(cc_ext);
            r_rr      <= ROW_W'(rr_ext);
            r_inner   <= inner;
        end
    end

    assign wr_lines.older = rd_lines.newer;
    assign wr_lines.newer = r_sample;

    sobel_line_store #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_store (
        .i_clk     (i_clk),
        .i_rd_en   (in_acc),
        .i_rd_addr (c_use),
        .o_rd_data (rd_lines),
        .i_wr_en   (r_state == S_READ),
        .i_wr_addr (r_cur_col),
        .i_wr_data (wr_lines)
    );

    sobel_grad u_grad (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (r_state == S_READ),
        .i_lines  (rd_lines),
        .i_sample (r_sample),
        .o_energy (energy)
    );

    assign sat             = (energy > sobel_pkg::ENERGY_W'(sobel_pkg::SAT_ENERGY));
    assign root_req.start  = (r_state == S_SQR) && r_inner && !sat;
    assign root_req.energy = energy[sobel_pkg::ROOT_IN_W-1:0];

    sobel_root u_root (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (root_req),
        .o_rsp   (root_rsp)
    );

    assign out_load = (r_state == S_DONE) && (!r_out_valid || o_edge.ready);

    always_comb begin
        n_state = r_state;
        n_value = r_value;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_GRAD;
            end
            S_GRAD: begin
                n_state = S_SQR;
            end
            S_SQR: begin
                if (!r_inner) begin
                    n_value = '0;
                    n_state = S_DONE;
                end else if (sat) begin
                    n_value = '1;
                    n_state = S_DONE;
                end else begin
                    n_state = S_ROOT;
                end
            end
            S_ROOT: begin
                if (root_rsp.done) begin
                    n_value = root_rsp.root;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_edge.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        if (out_load) begin
            r_out_edge     <= r_value;
            r_out_interior <= r_inner;
            r_out_col      <= sobel_pkg::CENTRE_COL_W'(r_cc);
            r_out_row      <= sobel_pkg::CENTRE_ROW_W'(r_rr);
        end
    end

    assign o_edge.valid      = r_out_valid;
    assign o_edge.edge_value = r_out_edge;
    assign o_edge.interior   = r_out_interior;
    assign o_edge.centre_col = r_out_col;
    assign o_edge.centre_row = r_out_row;

    a_acc_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_state == S_READ)
        else $error("request accepted outside idle sequence");

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (WID_W'(r_col) < r_width) && (HGT_W'(r_row) < r_height))
        else $error("raster position beyond frame geometry");

    a_border_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_interior |-> r_out_edge == '0)
        else $error("border result carries nonzero edge value");

    a_root_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE |-> !root_rsp.busy)
        else $error("square-root unit busy while idle");

endmodule
`default_nettype wire
